FILE: design/ske_pkg.sv
// Package for the sorted key set engine: command codes, key type and the
// control struct broadcast to every storage cell. No dependencies.
`default_nettype none
package ske_pkg;

   localparam logic [1:0] CMD_MEMBER = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   typedef logic signed [31:0] key_type;
   typedef logic [1:0]         cmd_type;

   typedef struct packed {
      logic    ins;
      logic    del;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: design/ske_cell.sv
// One storage cell of the sorted key chain: holds one key, compares it with
// the broadcast key and shifts with its neighbors. Depends on ske_pkg.
`default_nettype none
module ske_cell (
   input  wire                  clock,
   input  ske_pkg::cell_ctl_type ctl,
   input  ske_pkg::key_type     cmp_key,
   input  wire                  occ,
   input  ske_pkg::key_type     left_key,
   input  wire                  left_lt,
   input  ske_pkg::key_type     right_key,
   output logic                 lt,
   output logic                 eq,
   output ske_pkg::key_type     key_out
);
   import ske_pkg::*;

   key_type key_ff;
   key_type key_in;

   assign lt      = occ && (key_ff < cmp_key);
   assign eq      = occ && (key_ff == cmp_key);
   assign key_out = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.ins && !lt) begin
         key_in = left_lt ? cmp_key : left_key;
      end else if (ctl.del && !lt) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

FILE: design/sorted_key_set_engine.sv
// Top level of the sorted key set engine: request latch, key count and the
// chain of ske_cell storage cells. Depends on ske_pkg and ske_cell.
//
// Usage:
//   A transaction is accepted on the rising edge where start is high and busy
//   is low; req_cmd selects member query, insert or delete of req_key.
//   busy is high in the cycle after acceptance, in which every cell
//   compares its key with req_key at once; for an insert or delete that
//   takes effect, the cells from the key's position onward shift by one cell.
//   The result (rsp_ok, rsp_full_res) is shown for exactly one cycle with
//   rsp_valid, starting in the cycle after the busy cycle, and is taken at
//   the edge that ends it. The next transaction may be accepted at that
//   same edge; no new transaction is accepted during the single
//   compare-and-shift step of the chain.
//   The receiver cannot stall the result.
//   Reset clears the key count (the set is empty) and the control state;
//   cell contents are not cleared and are ignored above the count.
//   Unused command code 3 changes nothing and returns ok = 0.
`default_nettype none
module sorted_key_set_engine #(
   parameter int CAPACITY = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  ske_pkg::cmd_type req_cmd,
   input  ske_pkg::key_type req_key,
   output logic             rsp_valid,
   output logic             rsp_ok,
   output logic             rsp_full_res
);
   import ske_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic         busy_ff, busy_in;
   logic         valid_ff, valid_in;
   logic         ok_ff, ok_in;
   logic         full_ff, full_in;
   cmd_type      cmd_ff;
   key_type      key_ff;
   logic [CW-1:0] count_ff, count_in;

   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;
   key_type             cell_key [CAPACITY];
   cell_ctl_type        ctl;
   logic                present;
   logic                is_full;

   assign present = |eq_vec;
   assign is_full = (count_ff == CW'(CAPACITY));

   always_comb begin
      ctl.ins = busy_ff && (cmd_ff == CMD_INSERT) && !present && !is_full;
      ctl.del = busy_ff && (cmd_ff == CMD_DELETE) && present;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic    occ;
         logic    l_lt;
         key_type l_key;
         key_type r_key;
         assign occ = (CW'(gi) < count_ff);
         if (gi == 0) begin : g_first
            assign l_lt  = 1'b1;
            assign l_key = key_ff;
         end else begin : g_mid
            assign l_lt  = lt_vec[gi-1];
            assign l_key = cell_key[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign r_key = cell_key[gi];
         end else begin : g_inner
            assign r_key = cell_key[gi+1];
         end
         ske_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .cmp_key   (key_ff),
            .occ       (occ),
            .left_key  (l_key),
            .left_lt   (l_lt),
            .right_key (r_key),
            .lt        (lt_vec[gi]),
            .eq        (eq_vec[gi]),
            .key_out   (cell_key[gi])
         );
      end
   endgenerate

   always_comb begin
      busy_in  = busy_ff;
      valid_in = 1'b0;
      ok_in    = ok_ff;
      full_in  = full_ff;
      count_in = count_ff;
      if (busy_ff) begin
         busy_in  = 1'b0;
         valid_in = 1'b1;
         full_in  = 1'b0;
         case (cmd_ff)
            CMD_MEMBER: ok_in = present;
            CMD_INSERT: begin
               ok_in   = ctl.ins;
               full_in = !present && is_full;
            end
            CMD_DELETE: ok_in = present;
            default:    ok_in = 1'b0;
         endcase
         if (ctl.ins) begin
            count_in = count_ff + CW'(1);
         end else if (ctl.del) begin
            count_in = count_ff - CW'(1);
         end
      end else if (start) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      full_ff <= full_in;
      if (start && !busy_ff) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_full_res = full_ff;

endmodule
`default_nettype wire

FILE: design/ske_checker.sv
// Port-level checker for sorted_key_set_engine, attached by bind.
// Depends on ske_pkg and the top level's port list.
`default_nettype none
module ske_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input ske_pkg::cmd_type req_cmd,
   input wire              rsp_valid,
   input wire              rsp_ok,
   input wire              rsp_full_res
);
   import ske_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("busy cycle not followed by a single result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction");

   a_full_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> !rsp_ok && $past(req_cmd, 2) == CMD_INSERT)
      else $error("full flag on a result that is not a refused insert");

endmodule

bind sorted_key_set_engine ske_checker u_ske_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for sorted_key_set_engine: member, insert and delete
// transactions checked against a sorted-array predictor held in a scoreboard.
// Depends on ske_pkg and the sorted_key_set_engine RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ske_pkg::*;

   localparam int      CAPACITY     = 64;
   localparam int      RUN_LIMIT    = 100000;
   localparam int      DRAIN_CYCLES = 8;
   localparam int      POOL_SIZE    = 96;
   localparam cmd_type CMD_UNUSED   = 2'd3;
   localparam key_type KEY_MIN      = 32'sh8000_0000;
   localparam key_type KEY_MAX      = 32'sh7FFF_FFFF;

   typedef struct {
      logic    ok;
      logic    full_res;
      cmd_type cmd;
      key_type key;
   } reply_type;

   class key_set_scoreboard;
      key_type   keys[CAPACITY];
      int        count;
      reply_type pending[$];
      int        errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function void note_request(cmd_type cmd, key_type key);
         int        pos;
         int        i;
         bit        present;
         reply_type r;
         pos = 0;
         while (pos < count && keys[pos] < key)
            pos++;
         present    = (pos < count) && (keys[pos] == key);
         r.ok       = 1'b0;
         r.full_res = 1'b0;
         r.cmd      = cmd;
         r.key      = key;
         case (cmd)
            CMD_MEMBER: begin
               r.ok = present;
            end
            CMD_INSERT: begin
               if (!present) begin
                  if (count >= CAPACITY) begin
                     r.full_res = 1'b1;
                  end else begin
                     for (i = count; i > pos; i--)
                        keys[i] = keys[i - 1];
                     keys[pos] = key;
                     count++;
                     r.ok = 1'b1;
                  end
               end
            end
            CMD_DELETE: begin
               if (present) begin
                  for (i = pos; i + 1 < count; i++)
                     keys[i] = keys[i + 1];
                  count--;
                  r.ok = 1'b1;
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_reply(logic ok, logic full_res);
         reply_type exp;
         if (pending.size() == 0) begin
            $display("%0t: reply with no transaction outstanding: ok=%b full_res=%b",
                     $time, ok, full_res);
            errors++;
         end else begin
            exp = pending.pop_front();
            if (exp.ok !== ok) begin
               $display("%0t: cmd=%0d key=%0d ok expected %b actual %b",
                        $time, exp.cmd, exp.key, exp.ok, ok);
               errors++;
            end
            if (exp.full_res !== full_res) begin
               $display("%0t: cmd=%0d key=%0d full_res expected %b actual %b",
                        $time, exp.cmd, exp.key, exp.full_res, full_res);
               errors++;
            end
         end
      endfunction
   endclass

   logic    clock   = 1'b0;
   logic    reset   = 1'b1;
   logic    start   = 1'b0;
   cmd_type req_cmd = CMD_MEMBER;
   key_type req_key = '0;
   logic    busy;
   logic    rsp_valid;
   logic    rsp_ok;
   logic    rsp_full_res;

   key_set_scoreboard key_set = new();
   key_type           key_pool[POOL_SIZE];
   int                cycle_count = 0;

   sorted_key_set_engine #(.CAPACITY(CAPACITY)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ok       (rsp_ok),
      .rsp_full_res (rsp_full_res)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid)
         key_set.check_reply(rsp_ok, rsp_full_res);
      if (cycle_count >= RUN_LIMIT) begin
         $display("%0t: timeout, %0d transactions outstanding",
                  $time, key_set.pending.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(input cmd_type cmd, input key_type key);
      start   <= 1'b1;
      req_cmd <= cmd;
      req_key <= key;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      key_set.note_request(cmd, key);
   endtask

   task automatic sender_gap(input int idle_pct);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(0, 99) < 80)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return key_type'($urandom);
   endfunction

   function automatic cmd_type pick_cmd(input int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return CMD_UNUSED;
      if (r < 5 + ins_pct * 95 / 100)
         return CMD_INSERT;
      return $urandom_range(0, 1) ? CMD_MEMBER : CMD_DELETE;
   endfunction

   task automatic run_block(input int n, input int ins_pct, input int idle_pct);
      int k;
      for (k = 0; k < n; k++) begin
         sender_gap(idle_pct);
         send(pick_cmd(ins_pct), pick_key());
      end
   endtask

   initial begin
      int i;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = -32'sd1;
      for (i = 4; i < POOL_SIZE; i++)
         key_pool[i] = key_type'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(CMD_MEMBER, '0);
      send(CMD_DELETE, 32'sd5);
      send(CMD_INSERT, KEY_MIN);
      send(CMD_INSERT, KEY_MAX);
      send(CMD_INSERT, '0);
      send(CMD_INSERT, -32'sd1);
      send(CMD_INSERT, 32'sd1);
      send(CMD_INSERT, KEY_MAX);
      send(CMD_MEMBER, KEY_MIN);
      send(CMD_MEMBER, -32'sd1);
      send(CMD_MEMBER, 32'sd2);
      send(CMD_DELETE, '0);
      send(CMD_DELETE, '0);
      send(CMD_MEMBER, '0);
      send(CMD_UNUSED, KEY_MAX);
      send(CMD_UNUSED, '0);
      send(CMD_MEMBER, KEY_MAX);
      send(CMD_INSERT, 32'sh5555_5555);
      send(CMD_INSERT, 32'shAAAA_AAAA);
      send(CMD_DELETE, KEY_MIN);
      send(CMD_DELETE, KEY_MAX);
      send(CMD_MEMBER, 32'shAAAA_AAAA);

      // insert-heavy block fills the store so full refusals are exercised
      run_block(110, 90, 24);
      run_block(30, 50, 24);
      run_block(40, 20, 48);
      run_block(50, 60, 48);
      run_block(40, 80, 48);
      run_block(60, 50, 0);
      run_block(70, 85, 0);
      start <= 1'b0;

      while (key_set.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (key_set.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/ske_pkg.sv
design/ske_cell.sv
design/sorted_key_set_engine.sv
design/ske_checker.sv
verif/testbench.sv
